FILE: src/cil_pkg.sv
package cil_pkg;

  // Default sizes of the list.
  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 32;

  // Operation codes on the input channel.
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Status codes on the output channel.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  // Per-item command broadcast to every cell of the row.
  typedef struct packed {
    logic insert_ok;
    logic remove_ok;
  } cell_op_t;

endpackage

FILE: src/cil_cell.sv
module cil_cell #(
  parameter int IDX      = 0,
  parameter int ID_WIDTH = cil_pkg::ID_WIDTH_DEF,
  parameter int POS_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic                clk,
  input  logic [CNT_W-1:0]    count,
  input  logic [POS_W-1:0]    at,
  input  logic [ID_WIDTH-1:0] ident,
  input  cil_pkg::cell_op_t   op,
  input  logic [ID_WIDTH-1:0] next_entry,
  output logic [ID_WIDTH-1:0] entry,
  output logic                match
);

  logic occupied;

  // A cell holds a live entry only while its index is below the count.
  assign occupied = (CNT_W'(IDX) < count);
  assign match    = occupied && (entry == ident);

  // An insert lands in the first free cell; a remove pulls every cell at or
  // above the removed one down from its upper neighbor.
  always_ff @(posedge clk) begin
    if (op.insert_ok && (count == CNT_W'(IDX))) begin
      entry <= ident;
    end else if (op.remove_ok && (POS_W'(IDX) >= at)) begin
      entry <= next_entry;
    end
  end

endmodule

FILE: src/compacting_id_list_core.sv
// Ordered list of up to DEPTH unique identifiers kept as a row of cells, one
// entry per cell. Each item (insert, remove or find) is compared against all
// cells at once, and the list state is updated as the item is accepted, so a
// new item is accepted every cycle as long as the result register is free or
// being taken. A remove shifts all later cells down by one place, keeping
// insertion order. The user must write the capacity limit (cfg_we/cfg_wdata)
// only while the block is idle; the block itself does not enforce it. A limit
// of zero acts as one, a limit above DEPTH acts as DEPTH, and lowering the
// limit below the count drops nothing; inserts are then refused as full.
module compacting_id_list_core #(
  parameter int DEPTH    = cil_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = cil_pkg::ID_WIDTH_DEF,
  localparam int POS_W   = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [ID_WIDTH-1:0] ident,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [POS_W-1:0]    position,
  output logic [CNT_W-1:0]    entry_count,
  output logic                is_full,
  output logic                is_empty
);

  logic [CNT_W-1:0]    cap_limit;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    lim;
  logic [ID_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]    match;
  logic [POS_W-1:0]    at;
  logic                found;
  logic                in_accept;
  cil_pkg::cell_op_t   op;
  cil_pkg::status_t    st;
  logic [POS_W-1:0]    pos;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Effective capacity limit.
  always_comb begin
    if (cap_limit == '0) begin
      lim = CNT_W'(1);
    end else if (cap_limit > CNT_W'(DEPTH)) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = cap_limit;
    end
  end

  // Row of cells, each handing its entry to the cell below.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] upper;
    if (i == DEPTH - 1) begin : g_top
      assign upper = entry[i];
    end else begin : g_mid
      assign upper = entry[i+1];
    end
    cil_cell #(
      .IDX      (i),
      .ID_WIDTH (ID_WIDTH),
      .POS_W    (POS_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .count      (count),
      .at         (at),
      .ident      (ident),
      .op         (op),
      .next_entry (upper),
      .entry      (entry[i]),
      .match      (match[i])
    );
  end

  // Identifiers are unique, so at most one cell matches and an OR of the
  // matching indexes gives its position.
  always_comb begin
    at = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        at = at | POS_W'(i);
      end
    end
  end
  assign found = |match;

  // Decode the item into a cell command, a status and a position.
  always_comb begin
    op  = '0;
    st  = cil_pkg::ST_NOT_FOUND;
    pos = '0;
    case (cil_pkg::func_t'(func))
      cil_pkg::FUNC_INSERT: begin
        if (found) begin
          st = cil_pkg::ST_DUPLICATE;
        end else if (count >= lim) begin
          st = cil_pkg::ST_FULL;
        end else begin
          st           = cil_pkg::ST_OK;
          pos          = count[POS_W-1:0];
          op.insert_ok = in_accept;
        end
      end
      cil_pkg::FUNC_REMOVE: begin
        if (found) begin
          st           = cil_pkg::ST_OK;
          pos          = at;
          op.remove_ok = in_accept;
        end
      end
      cil_pkg::FUNC_FIND: begin
        if (found) begin
          st  = cil_pkg::ST_OK;
          pos = at;
        end
      end
      default: begin
        st = cil_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Count after the item.
  always_comb begin
    count_next = count;
    if (op.insert_ok) begin
      count_next = count + CNT_W'(1);
    end else if (op.remove_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Control state: limit register, count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CNT_W'(DEPTH);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_limit <= cfg_wdata;
      end
      count <= count_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register for the item just taken.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status      <= st;
      position    <= pos;
      entry_count <= count_next;
      is_full     <= (count_next >= lim);
      is_empty    <= (count_next == '0);
    end
  end

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // Stored identifiers stay unique, so no two live cells ever match.
  a_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("identifier present in more than one cell");

  // A successful insert grows the count by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op.insert_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // A result only appears after an item was accepted.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept))
    else $error("result without accepted item");

endmodule
